// File: rtl/core/crfs_pkg.sv
`default_nettype none

package crfs_pkg;

    // controller command bytes
    localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
    localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

    // panel size limits and reset values
    localparam logic [12:0] PANEL_LIMIT  = 13'd4096;
    localparam logic [12:0] WIDTH_RESET  = 13'd480;
    localparam logic [12:0] HEIGHT_RESET = 13'd320;

    // configuration register indexes
    localparam logic CFG_PANEL_WIDTH  = 1'b0;
    localparam logic CFG_PANEL_HEIGHT = 1'b1;

    // input word modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // header sequence steps, pixel phase after the last one
    localparam logic [3:0] STEP_COLUMN_CMD   = 4'd0;
    localparam logic [3:0] STEP_LEFT_HIGH    = 4'd1;
    localparam logic [3:0] STEP_LEFT_LOW     = 4'd2;
    localparam logic [3:0] STEP_RIGHT_HIGH   = 4'd3;
    localparam logic [3:0] STEP_RIGHT_LOW    = 4'd4;
    localparam logic [3:0] STEP_ROW_CMD      = 4'd5;
    localparam logic [3:0] STEP_TOP_HIGH     = 4'd6;
    localparam logic [3:0] STEP_TOP_LOW      = 4'd7;
    localparam logic [3:0] STEP_BOTTOM_HIGH  = 4'd8;
    localparam logic [3:0] STEP_BOTTOM_LOW   = 4'd9;
    localparam logic [3:0] STEP_MEMORY_CMD   = 4'd10;
    localparam logic [3:0] PIXEL_PHASE       = 4'd11;

    // colour byte order within a pixel
    localparam logic [1:0] COLOUR_RED   = 2'd0;
    localparam logic [1:0] COLOUR_GREEN = 2'd1;
    localparam logic [1:0] COLOUR_BLUE  = 2'd2;

    // one fill request as carried by a load word
    typedef struct packed {
        logic [15:0] left_column;
        logic [15:0] top_row;
        logic [15:0] rect_width;
        logic [15:0] rect_height;
        logic [7:0]  red_level;
        logic [7:0]  green_level;
        logic [7:0]  blue_level;
    } fill_req_t;

    // clipped window handed to the sequencer
    typedef struct packed {
        logic        accept;
        logic [15:0] left;
        logic [15:0] right;
        logic [15:0] top;
        logic [15:0] bottom;
        logic [11:0] cols_m1;
        logic [11:0] rows_m1;
    } window_t;

endpackage

`default_nettype wire

// File: rtl/core/crfs_clip.sv
`default_nettype none

module crfs_clip (
    input  wire crfs_pkg::fill_req_t req,
    input  wire [12:0]               panel_width,
    input  wire [12:0]               panel_height,
    output crfs_pkg::window_t        win
);
    import crfs_pkg::*;

    logic [12:0] pw;
    logic [12:0] ph;
    logic [16:0] x_end;
    logic [16:0] y_end;
    logic        x_over;
    logic        y_over;
    logic [12:0] cols_m1_full;
    logic [12:0] rows_m1_full;

    // panel registers above the limit act as the limit
    assign pw = (panel_width  > PANEL_LIMIT) ? PANEL_LIMIT : panel_width;
    assign ph = (panel_height > PANEL_LIMIT) ? PANEL_LIMIT : panel_height;

    // rectangle extent against the panel edge
    assign x_end  = {1'b0, req.left_column} + {1'b0, req.rect_width};
    assign y_end  = {1'b0, req.top_row} + {1'b0, req.rect_height};
    assign x_over = x_end > {4'b0, pw};
    assign y_over = y_end > {4'b0, ph};

    // clipped sizes minus one, within 12 bits once accepted
    assign cols_m1_full = x_over ? (pw - req.left_column[12:0] - 13'd1)
                                 : (req.rect_width[12:0] - 13'd1);
    assign rows_m1_full = y_over ? (ph - req.top_row[12:0] - 13'd1)
                                 : (req.rect_height[12:0] - 13'd1);

    // drop empty rectangles and ones that start off the panel
    always_comb
    begin
        win.accept  = (req.rect_width != 16'd0) && (req.rect_height != 16'd0) &&
                      (req.left_column < {3'b0, pw}) && (req.top_row < {3'b0, ph});
        win.left    = req.left_column;
        win.top     = req.top_row;
        win.right   = x_over ? {3'b0, pw - 13'd1} : (x_end[15:0] - 16'd1);
        win.bottom  = y_over ? {3'b0, ph - 13'd1} : (y_end[15:0] - 16'd1);
        win.cols_m1 = cols_m1_full[11:0];
        win.rows_m1 = rows_m1_full[11:0];
    end

endmodule

`default_nettype wire

// File: rtl/core/crfs_sequencer.sv
`default_nettype none

module crfs_sequencer (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      take,
    input  wire                      mode,
    input  wire crfs_pkg::fill_req_t req,
    input  wire crfs_pkg::window_t   win,
    input  wire                      out_ready,
    output logic                     out_valid,
    output logic [7:0]               out_byte,
    output logic                     out_is_data,
    output logic                     out_last
);
    import crfs_pkg::*;

    logic        busy_reg, busy_next;
    logic [3:0]  step_reg, step_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] right_reg, right_next;
    logic [15:0] top_reg, top_next;
    logic [15:0] bottom_reg, bottom_next;
    logic [23:0] colour_reg, colour_next;
    logic [11:0] cols_m1_reg, cols_m1_next;
    logic [11:0] col_cnt_reg, col_cnt_next;
    logic [11:0] row_cnt_reg, row_cnt_next;
    logic [1:0]  cidx_reg, cidx_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        data_reg, data_next;
    logic        last_reg, last_next;
    logic        emit;

    // byte selection and fill state update
    always_comb
    begin
        busy_next    = busy_reg;
        step_next    = step_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        top_next     = top_reg;
        bottom_next  = bottom_reg;
        colour_next  = colour_reg;
        cols_m1_next = cols_m1_reg;
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        cidx_next    = cidx_reg;
        emit         = 1'b0;
        byte_next    = byte_reg;
        data_next    = 1'b1;
        last_next    = 1'b0;
        if (take && mode == MODE_LOAD)
        begin
            busy_next = win.accept;
            if (win.accept)
            begin
                left_next    = win.left;
                right_next   = win.right;
                top_next     = win.top;
                bottom_next  = win.bottom;
                colour_next  = {req.red_level, req.green_level, req.blue_level};
                cols_m1_next = win.cols_m1;
                col_cnt_next = win.cols_m1;
                row_cnt_next = win.rows_m1;
                cidx_next    = COLOUR_RED;
                step_next    = STEP_COLUMN_CMD;
            end
        end
        else if (take && busy_reg)
        begin
            emit = 1'b1;
            if (step_reg < PIXEL_PHASE)
            begin
                step_next = step_reg + 4'd1;
                unique case (step_reg)
                    STEP_COLUMN_CMD:  begin byte_next = CMD_COLUMN_SET; data_next = 1'b0; end
                    STEP_LEFT_HIGH:   byte_next = left_reg[15:8];
                    STEP_LEFT_LOW:    byte_next = left_reg[7:0];
                    STEP_RIGHT_HIGH:  byte_next = right_reg[15:8];
                    STEP_RIGHT_LOW:   byte_next = right_reg[7:0];
                    STEP_ROW_CMD:     begin byte_next = CMD_ROW_SET; data_next = 1'b0; end
                    STEP_TOP_HIGH:    byte_next = top_reg[15:8];
                    STEP_TOP_LOW:     byte_next = top_reg[7:0];
                    STEP_BOTTOM_HIGH: byte_next = bottom_reg[15:8];
                    STEP_BOTTOM_LOW:  byte_next = bottom_reg[7:0];
                    default:          begin byte_next = CMD_MEMORY_WRITE; data_next = 1'b0; end
                endcase
            end
            else
            begin
                unique case (cidx_reg)
                    COLOUR_RED:
                    begin
                        byte_next = colour_reg[23:16];
                        cidx_next = COLOUR_GREEN;
                    end
                    COLOUR_GREEN:
                    begin
                        byte_next = colour_reg[15:8];
                        cidx_next = COLOUR_BLUE;
                    end
                    default:
                    begin
                        // end of a pixel: step the column and row counters
                        byte_next = colour_reg[7:0];
                        cidx_next = COLOUR_RED;
                        if (col_cnt_reg != 12'd0)
                        begin
                            col_cnt_next = col_cnt_reg - 12'd1;
                        end
                        else if (row_cnt_reg != 12'd0)
                        begin
                            row_cnt_next = row_cnt_reg - 12'd1;
                            col_cnt_next = cols_m1_reg;
                        end
                        else
                        begin
                            last_next = 1'b1;
                            busy_next = 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    // output register holds a word until taken
    assign valid_next = emit | (valid_reg & ~out_ready);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= STEP_COLUMN_CMD;
            cidx_reg  <= COLOUR_RED;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            cidx_reg  <= cidx_next;
            valid_reg <= valid_next;
        end
    end

    // payload state
    always_ff @(posedge clk)
    begin
        left_reg    <= left_next;
        right_reg   <= right_next;
        top_reg     <= top_next;
        bottom_reg  <= bottom_next;
        colour_reg  <= colour_next;
        cols_m1_reg <= cols_m1_next;
        col_cnt_reg <= col_cnt_next;
        row_cnt_reg <= row_cnt_next;
        if (emit)
        begin
            byte_reg <= byte_next;
            data_reg <= data_next;
            last_reg <= last_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign out_is_data = data_reg;
    assign out_last    = last_reg;

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg <= PIXEL_PHASE)
        else $error("header step beyond pixel phase");
    a_colour_index: assert property (@(posedge clk) disable iff (!rst_n)
        cidx_reg != 2'd3)
        else $error("colour byte index out of range");
    a_last_ends_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last_next) |=> (!busy_reg && valid_reg && out_last && out_is_data))
        else $error("last word did not end the fill");
`endif

endmodule

`default_nettype wire

// File: rtl/core/clipped_rect_fill_streamer_unit.sv
`default_nettype none

// a byte request appears on the master side in the cycle after it is taken
// throughput: one word per cycle unless m_tready stalls; an input register
// and an output register part the two sides, and every stage uses short logic only
// a load word produces no output; a fill of w by h pixels emits 11 + 3*w*h words
// reset (rst_n, asynchronous, active low) clears the handshake and fill control
// state and sets the panel registers to 480 by 320

module clipped_rect_fill_streamer_unit (
    input  wire         clk,
    input  wire         rst_n,
    // configuration write port
    input  wire         cfg_wen,
    input  wire         cfg_index,
    input  wire [12:0]  cfg_wdata,
    // slave side
    input  wire         s_tvalid,
    output logic        s_tready,
    // tdata: left_column[15:0], top_row[31:16], rect_width[47:32],
    // rect_height[63:48], red_level[71:64], green_level[79:72], blue_level[87:80]
    input  wire [87:0]  s_tdata,
    // tuser: mode[0]
    input  wire         s_tuser,
    // master side
    output logic        m_tvalid,
    input  wire         m_tready,
    // tdata: lane_byte[7:0]
    output logic [7:0]  m_tdata,
    // tuser: is_data[0]
    output logic        m_tuser,
    output logic        m_tlast
);
    import crfs_pkg::*;

    logic [12:0] panel_width_reg;
    logic [12:0] panel_height_reg;
    logic        in_valid_reg;
    logic        in_mode_reg;
    fill_req_t   in_req_reg;
    fill_req_t   s_req;
    window_t     win;
    logic        take;

    // input word unpacked
    assign s_req.left_column = s_tdata[15:0];
    assign s_req.top_row     = s_tdata[31:16];
    assign s_req.rect_width  = s_tdata[47:32];
    assign s_req.rect_height = s_tdata[63:48];
    assign s_req.red_level   = s_tdata[71:64];
    assign s_req.green_level = s_tdata[79:72];
    assign s_req.blue_level  = s_tdata[87:80];

    // stage hand-off: the held word moves on once the output slot is free
    assign take     = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || take;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_width_reg  <= WIDTH_RESET;
            panel_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_PANEL_WIDTH:  panel_width_reg  <= cfg_wdata;
                CFG_PANEL_HEIGHT: panel_height_reg <= cfg_wdata;
                default:          panel_width_reg  <= panel_width_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg <= s_tuser;
            in_req_reg  <= s_req;
        end
    end

    // window clipping
    crfs_clip u_clip (
        .req          (in_req_reg),
        .panel_width  (panel_width_reg),
        .panel_height (panel_height_reg),
        .win          (win)
    );

    // byte sequencer and output register
    crfs_sequencer u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .mode        (in_mode_reg),
        .req         (in_req_reg),
        .win         (win),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_byte    (m_tdata),
        .out_is_data (m_tuser),
        .out_last    (m_tlast)
    );

endmodule

`default_nettype wire
